[rtl/hbns_pkg.sv]
package hbns_pkg;

  localparam int POS_W      = 12;
  localparam int WORD_W     = 6;
  localparam int BIT_W      = 6;
  localparam int LEAF_BITS  = 64;
  localparam int LEAF_WORDS = 64;
  localparam int CAPACITY   = 4096;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_PREV  = 2'd2,
    OP_NEXT  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic accept;
    logic word_step;
    logic neigh_step;
  } hbns_cmd_t;

  typedef struct packed {
    logic go_second;
  } hbns_status_t;

endpackage

[rtl/hbns_datapath.sv]
module hbns_datapath
  import hbns_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  hbns_cmd_t            cmd,
  output hbns_status_t         status,
  input  logic [1:0]           opcode,
  input  logic [POS_W-1:0]     position,
  output logic                 found,
  output logic [POS_W-1:0]     result_position
);

  function automatic logic [BIT_W-1:0] high_index(input logic [LEAF_BITS-1:0] v);
    logic [LEAF_BITS-1:0] x;
    logic [BIT_W-1:0]     idx;
    x   = v;
    idx = '0;
    for (int s = BIT_W - 1; s >= 0; s--) begin
      if ((x >> (1 << s)) != '0) begin
        idx[s] = 1'b1;
        x      = x >> (1 << s);
      end
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] low_index(input logic [LEAF_BITS-1:0] v);
    logic [LEAF_BITS-1:0] x;
    logic [BIT_W-1:0]     idx;
    x   = v;
    idx = '0;
    for (int s = BIT_W - 1; s >= 0; s--) begin
      if ((x & ((LEAF_BITS'(1) << (1 << s)) - LEAF_BITS'(1))) == '0) begin
        idx[s] = 1'b1;
        x      = x >> (1 << s);
      end
    end
    return idx;
  endfunction

  logic [LEAF_BITS-1:0] leaf_mem [LEAF_WORDS];
  logic [LEAF_BITS-1:0] rdata;
  logic [WORD_W-1:0]    rd_idx;
  logic [WORD_W-1:0]    raddr;
  logic [LEAF_BITS-1:0] summary;

  opcode_t              op;
  logic [WORD_W-1:0]    word_idx;
  logic [BIT_W-1:0]     bit_idx;
  logic                 in_range;

  logic [LEAF_BITS-1:0] leaf_word;
  logic [LEAF_BITS-1:0] bit_sel;
  logic [LEAF_BITS-1:0] below_bit;
  logic [LEAF_BITS-1:0] above_bit;
  logic [LEAF_BITS-1:0] word_sel;
  logic [LEAF_BITS-1:0] below_word;
  logic [LEAF_BITS-1:0] above_word;
  logic [LEAF_BITS-1:0] local_hits;
  logic [LEAF_BITS-1:0] word_hits;
  logic [LEAF_BITS-1:0] new_word;
  logic [WORD_W-1:0]    neigh_idx;
  logic                 is_prev;
  logic                 is_query;
  logic                 wr_en;
  logic                 word_found;
  logic [POS_W-1:0]     word_pos;
  logic [BIT_W-1:0]     neigh_bit;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op       <= opcode_t'(opcode);
      word_idx <= position[POS_W-1:BIT_W];
      bit_idx  <= position[BIT_W-1:0];
      in_range <= (32'(position) < CAPACITY);
    end
  end

  // an entry whose summary bit is clear is empty, whatever the array holds
  assign leaf_word = summary[rd_idx] ? rdata : '0;

  assign is_prev  = (op == OP_PREV);
  assign is_query = (op == OP_PREV) || (op == OP_NEXT);

  assign bit_sel    = LEAF_BITS'(1) << bit_idx;
  assign below_bit  = bit_sel - LEAF_BITS'(1);
  assign above_bit  = ~(below_bit | bit_sel);
  assign word_sel   = LEAF_BITS'(1) << word_idx;
  assign below_word = word_sel - LEAF_BITS'(1);
  assign above_word = ~(below_word | word_sel);

  assign local_hits = leaf_word & (is_prev ? below_bit : above_bit);
  assign word_hits  = summary & (is_prev ? below_word : above_word);
  assign neigh_idx  = is_prev ? high_index(word_hits) : low_index(word_hits);

  assign status.go_second = is_query && (local_hits == '0) && (word_hits != '0);

  assign new_word = (op == OP_SET) ? (leaf_word | bit_sel) : (leaf_word & ~bit_sel);
  assign wr_en    = cmd.word_step && !is_query && in_range;

  always_comb begin
    word_found = 1'b0;
    word_pos   = '0;
    if (is_query && (local_hits != '0)) begin
      word_found = 1'b1;
      word_pos   = {word_idx, is_prev ? high_index(local_hits) : low_index(local_hits)};
    end
  end

  assign neigh_bit = is_prev ? high_index(leaf_word) : low_index(leaf_word);

  // first read at the accept edge, neighbour word read after the summary lookup
  assign raddr = cmd.word_step ? neigh_idx : position[POS_W-1:BIT_W];

  always_ff @(posedge clk) begin
    rdata  <= leaf_mem[raddr];
    rd_idx <= raddr;
    if (wr_en) begin
      leaf_mem[word_idx] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      summary <= '0;
    end else if (wr_en) begin
      summary[word_idx] <= (new_word != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_step && !status.go_second) begin
      found           <= word_found;
      result_position <= word_pos;
    end else if (cmd.neigh_step) begin
      found           <= 1'b1;
      result_position <= {rd_idx, neigh_bit};
    end
  end

endmodule

[rtl/hbns_controller.sv]
module hbns_controller
  import hbns_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  output logic         done,
  output hbns_cmd_t    cmd,
  input  hbns_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORD,
    S_NEIGH
  } state_t;

  state_t state;

  assign busy           = (state != S_IDLE);
  assign cmd.accept     = (state == S_IDLE) && start;
  assign cmd.word_step  = (state == S_WORD);
  assign cmd.neigh_step = (state == S_NEIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_WORD;
          end
        end
        S_WORD: begin
          if (status.go_second) begin
            state <= S_NEIGH;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_NEIGH: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/hierarchical_bitmap_neighbour_search.sv]
// channel   ports                           transaction
// command   start, busy, opcode, position   start high while busy low
// result    done, found, result_position    done high for one cycle
//
// set and clear read the leaf, then write it and update the summary.
// a query reads its leaf word; when the answer lies in another leaf word, that word is
// read in a further step after the summary lookup. Leaf memory reads are registered.
// reset clears the summary word; no clearing pass over the leaves.
// done rises the cycle after the last step, when busy is already low, so a new
// command may be taken in the same cycle; the receiver cannot stall results.
module hierarchical_bitmap_neighbour_search
  import hbns_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [POS_W-1:0] position,
  output logic             done,
  output logic             found,
  output logic [POS_W-1:0] result_position
);

  hbns_cmd_t    cmd;
  hbns_status_t status;

  hbns_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  hbns_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .opcode          (opcode),
    .position        (position),
    .found           (found),
    .result_position (result_position)
  );

endmodule

[rtl/hbns_checker.sv]
module hbns_checker
  import hbns_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             found,
  input logic [POS_W-1:0] result_position
);

  // a result only appears once the command has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not hold busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in flight");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (result_position == '0))
    else $error("nonzero position without a find");

endmodule

bind hierarchical_bitmap_neighbour_search hbns_checker u_hbns_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .found           (found),
  .result_position (result_position)
);

[sim/hierarchical_bitmap_neighbour_search_checker.sv]
`timescale 1ns / 1ps
module hierarchical_bitmap_neighbour_search_checker
  import hbns_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       opcode,
  input  logic [POS_W-1:0] position,
  input  logic             done,
  input  logic             found,
  input  logic [POS_W-1:0] result_position,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    opcode_t          op;
    logic [POS_W-1:0] origin;
    logic             hit;
    logic [POS_W-1:0] nearest;
  } answer_t;

  logic [LEAF_BITS-1:0]  marks [LEAF_WORDS];
  logic [LEAF_WORDS-1:0] occupied;
  answer_t               answer_q [$];
  int                    fail_total;

  function automatic int top_bit(input logic [LEAF_BITS-1:0] v);
    int r = 0;
    for (int i = 0; i < LEAF_BITS; i++)
      if (v[i]) r = i;
    return r;
  endfunction

  function automatic int bottom_bit(input logic [LEAF_BITS-1:0] v);
    int r = 0;
    for (int i = LEAF_BITS - 1; i >= 0; i--)
      if (v[i]) r = i;
    return r;
  endfunction

  initial begin
    fail_total = 0;
    occupied = '0;
    for (int i = 0; i < LEAF_WORDS; i++) marks[i] = '0;
  end

  always @(posedge clk) begin
    answer_t              want;
    logic [WORD_W-1:0]    w;
    logic [BIT_W-1:0]     b;
    logic [LEAF_BITS-1:0] m;
    int                   nw;
    if (rst) begin
      for (int i = 0; i < LEAF_WORDS; i++) marks[i] = '0;
      occupied = '0;
      answer_q.delete();
    end else begin
      // results leave before the next transaction is taken, so check first
      if (done) begin
        if (answer_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("unexpected result: found=%0d position=%0d", found, result_position);
        end else begin
          want = answer_q.pop_front();
          if (want.hit !== found || want.nearest !== result_position) begin
            fail_total++;
            if (fail_total <= 10)
              $display("mismatch on %s from %0d: expected %0d/%0d, got %0d/%0d",
                       want.op.name(), want.origin, want.hit, want.nearest, found,
                       result_position);
          end
        end
      end
      if (start && !busy) begin
        w = position[POS_W-1:BIT_W];
        b = position[BIT_W-1:0];
        want = '0;
        want.op = opcode_t'(opcode);
        want.origin = position;
        case (opcode_t'(opcode))
          OP_SET, OP_CLEAR: begin
            if (int'(position) < CAPACITY) begin
              marks[w][b] = (opcode_t'(opcode) == OP_SET);
              occupied[w] = |marks[w];
            end
          end
          OP_PREV: begin
            m = marks[w] & ((64'd1 << b) - 64'd1);
            if (m != '0) begin
              want.hit = 1'b1;
              want.nearest = {w, BIT_W'(top_bit(m))};
            end else begin
              // fall back to the summary word for a lower non-empty leaf
              m = occupied & ((64'd1 << w) - 64'd1);
              if (m != '0) begin
                nw = top_bit(m);
                want.hit = 1'b1;
                want.nearest = {WORD_W'(nw), BIT_W'(top_bit(marks[nw]))};
              end
            end
          end
          OP_NEXT: begin
            m = (b == BIT_W'(LEAF_BITS - 1)) ? '0 : marks[w] & (~64'd0 << (b + 1));
            if (m != '0) begin
              want.hit = 1'b1;
              want.nearest = {w, BIT_W'(bottom_bit(m))};
            end else begin
              m = (w == WORD_W'(LEAF_WORDS - 1)) ? '0 : occupied & (~64'd0 << (w + 1));
              if (m != '0) begin
                nw = bottom_bit(m);
                want.hit = 1'b1;
                want.nearest = {WORD_W'(nw), BIT_W'(bottom_bit(marks[nw]))};
              end
            end
          end
          default: ;
        endcase
        answer_q.insert(answer_q.size(), want);
      end
    end
    mismatches  <= fail_total;
    outstanding <= answer_q.size();
  end

endmodule

[sim/hierarchical_bitmap_neighbour_search_tb.sv]
`timescale 1ns / 1ps
module hierarchical_bitmap_neighbour_search_tb;
  import hbns_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 45;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       opcode = OP_SET;
  logic [POS_W-1:0] position = '0;
  logic             busy;
  logic             done;
  logic             found;
  logic [POS_W-1:0] result_position;
  int               mismatches;
  int               outstanding;
  int               quiet_cycles = 0;

  hierarchical_bitmap_neighbour_search uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .position        (position),
    .done            (done),
    .found           (found),
    .result_position (result_position)
  );

  hierarchical_bitmap_neighbour_search_checker neighbour_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .position        (position),
    .done            (done),
    .found           (found),
    .result_position (result_position),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a run that stops moving transactions is a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[hierarchical_bitmap_neighbour_search] ERROR");
        $finish;
      end
    end
  end

  // start stays high across back-to-back commands
  task automatic issue(input opcode_t op, input logic [POS_W-1:0] pos);
    start    <= 1'b1;
    opcode   <= op;
    position <= pos;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) begin
        opcode   <= 2'($urandom);
        position <= POS_W'($urandom);
        @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int                left;
    int                burst;
    int                gap;
    int                style;
    int                r;
    int                walk;
    bit                clear_heavy;
    bit                no_idle;
    logic [WORD_W-1:0] hot [3];
    logic [POS_W-1:0]  pos;
    opcode_t           op;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty set, then the corners and word boundaries
    issue(OP_NEXT, 12'd0);
    issue(OP_PREV, 12'd4095);
    issue(OP_PREV, 12'd0);
    issue(OP_SET, 12'd0);
    issue(OP_SET, 12'd4095);
    issue(OP_SET, 12'd63);
    issue(OP_SET, 12'd64);
    issue(OP_SET, 12'd0);
    issue(OP_PREV, 12'd4095);
    issue(OP_NEXT, 12'd0);
    issue(OP_NEXT, 12'd4095);
    issue(OP_PREV, 12'd0);
    issue(OP_CLEAR, 12'd100);
    issue(OP_CLEAR, 12'd0);
    issue(OP_NEXT, 12'd4094);
    issue(OP_PREV, 12'd64);
    issue(OP_PREV, 12'd63);
    issue(OP_NEXT, 12'd63);
    issue(OP_CLEAR, 12'd64);
    issue(OP_NEXT, 12'd63);
    issue(OP_PREV, 12'd2000);
    issue(OP_SET, 12'd2048);
    issue(OP_SET, 12'd2049);
    issue(OP_PREV, 12'd2049);
    issue(OP_NEXT, 12'd2047);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      style       = $urandom_range(0, 3);
      clear_heavy = (phase % 3 == 2);
      no_idle     = (phase == 4);
      walk        = 0;
      foreach (hot[i]) hot[i] = WORD_W'($urandom);
      if ($urandom_range(0, 3) == 0) hot[0] = '0;
      if ($urandom_range(0, 3) == 0) hot[2] = '1;
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        if (burst > left) burst = left;
        repeat (burst) begin
          case (style)
            0: pos = POS_W'($urandom);
            1: pos = {hot[$urandom_range(0, 2)], BIT_W'($urandom)};
            2: begin
              r = $urandom_range(0, 4);
              case (r)
                0: pos = '0;
                1: pos = '1;
                2: pos = {WORD_W'($urandom), {BIT_W{1'b0}}};
                3: pos = {WORD_W'($urandom), {BIT_W{1'b1}}};
                default: pos = POS_W'($urandom);
              endcase
            end
            default: begin
              // walk through the bits of one word in order
              pos = {hot[0], BIT_W'(walk)};
              walk++;
            end
          endcase
          r = $urandom_range(0, 99);
          if (clear_heavy)
            op = (r < 15) ? OP_SET : (r < 60) ? OP_CLEAR : (r < 80) ? OP_PREV : OP_NEXT;
          else
            op = (r < 45) ? OP_SET : (r < 60) ? OP_CLEAR : (r < 80) ? OP_PREV : OP_NEXT;
          issue(op, pos);
        end
        left -= burst;
        gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        pause(gap);
      end
      // hold off now and then until the block has caught up
      if (phase % 2 == 1) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[hierarchical_bitmap_neighbour_search] OK");
    else
      $display("[hierarchical_bitmap_neighbour_search] ERROR");
    $finish;
  end

endmodule
